[sv/egbce_pkg.sv]
package egbce_pkg;

    localparam int unsigned WordW = 32;
    localparam int unsigned DefExpBits = 64;
    localparam int unsigned QueueDepth = 2;
    localparam logic [WordW-1:0] ResetModulus = 32'hFFFF_FFFB;
    localparam logic [WordW-1:0] ResetGenerator = 32'd2;
    localparam logic [WordW-1:0] ResetPublic = 32'd1;
    localparam logic [WordW-1:0] ResetPrivate = 32'd1;

    localparam logic [1:0] RegModulus = 2'd0;
    localparam logic [1:0] RegGenerator = 2'd1;
    localparam logic [1:0] RegPublic = 2'd2;
    localparam logic [1:0] RegPrivate = 2'd3;

    localparam logic KindEncrypt = 1'b0;
    localparam logic KindDecrypt = 1'b1;

    // One classified request as it waits in the queue.
    typedef struct packed {
        logic             kind;
        logic             trivial;
        logic [WordW-1:0] base_a;
        logic [WordW-1:0] base_b;
        logic [WordW-1:0] expo;
        logic [WordW-1:0] factor;
    } t_job;

endpackage

[sv/elgamal_block_cipher_engine_top.sv]
// ElGamal block engine over a prime modulus of up to 32 bits. An encrypt
// request returns g^k mod p and e^k*m mod p; a decrypt request returns
// C1^(p-1-d)*C2 mod p and zero. Every modular product runs in one shared
// bit-serial multiplier, and each of the three operand reductions runs in
// a bit-serial reducer; a request whose modulus is below two skips the
// arithmetic and returns zeros. Requests queue in front and results wait
// in an output register, so input and output stall independently.
module elgamal_block_cipher_engine_top #(
    parameter int unsigned ExpBits = egbce_pkg::DefExpBits
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,  // message_block, nonce, cipher_first, cipher_second
    input  logic          s_axis_tuser,  // kind
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata,  // result_first, result_second
    output logic          m_axis_tuser   // result_kind
);
    logic [31:0] r_p, r_g, r_e, r_d;
    logic job_valid, job_take;
    egbce_pkg::t_job job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p <= egbce_pkg::ResetModulus;
            r_g <= egbce_pkg::ResetGenerator;
            r_e <= egbce_pkg::ResetPublic;
            r_d <= egbce_pkg::ResetPrivate;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                egbce_pkg::RegModulus: r_p <= i_cfg_data;
                egbce_pkg::RegGenerator: r_g <= i_cfg_data;
                egbce_pkg::RegPublic: r_e <= i_cfg_data;
                egbce_pkg::RegPrivate: r_d <= i_cfg_data;
                default: ;
            endcase
        end
    end

    egbce_front #(.QDepth(egbce_pkg::QueueDepth)) u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_kind(s_axis_tuser),
        .i_msg(s_axis_tdata[31:0]), .i_nonce(s_axis_tdata[63:32]),
        .i_c1(s_axis_tdata[95:64]), .i_c2(s_axis_tdata[127:96]),
        .i_p(r_p), .i_g(r_g), .i_e(r_e), .i_d(r_d),
        .o_job_valid(job_valid), .i_job_take(job_take), .o_job(job));

    egbce_back #(.ExpBits(ExpBits)) u_back (
        .i_clk, .i_rst_n,
        .i_job_valid(job_valid), .o_job_take(job_take), .i_job(job), .i_p(r_p),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_kind(m_axis_tuser),
        .o_first(m_axis_tdata[31:0]), .o_second(m_axis_tdata[63:32]));
endmodule

[sv/egbce_modmul.sv]
// Sequential modular multiplier: a*b mod n, interleaved shift-add,
// one multiplier bit per cycle.
module egbce_modmul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [egbce_pkg::WordW-1:0]  i_a,
    input  logic [egbce_pkg::WordW-1:0]  i_b,
    input  logic [egbce_pkg::WordW-1:0]  i_n,
    output logic                         o_done,
    output logic [egbce_pkg::WordW-1:0]  o_p
);
    localparam int unsigned W = egbce_pkg::WordW;
    localparam int unsigned CntW = $clog2(W + 1);

    logic [CntW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic [W-1:0]    r_acc, n_acc;
    logic [W-1:0]    r_a, n_a;
    logic [W-1:0]    r_b, n_b;
    logic [W+1:0]    s_dbl, s_add, s_t;
    logic [W-1:0]    s_amod;

    // The multiplicand must already be below n; the accumulator then stays
    // below n with one compare and subtract after doubling and after adding.
    assign s_amod = r_a;
    always_comb begin
        s_dbl = {1'b0, r_acc, 1'b0};
        if (s_dbl >= {2'b00, i_n}) s_dbl = s_dbl - {2'b00, i_n};
        s_add = s_dbl + (r_b[W-1] ? {2'b00, s_amod} : '0);
        s_t = s_add;
        if (s_t >= {2'b00, i_n}) s_t = s_t - {2'b00, i_n};
    end

    always_comb begin
        n_cnt = r_cnt;
        n_busy = r_busy;
        n_acc = r_acc;
        n_a = r_a;
        n_b = r_b;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt = CntW'(W);
            n_acc = '0;
            n_a = i_a;
            n_b = i_b;
        end else if (r_busy) begin
            n_acc = s_t[W-1:0];
            n_b = {r_b[W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt <= n_cnt;
        end
        r_acc <= n_acc;
        r_a <= n_a;
        r_b <= n_b;
    end

    assign o_done = r_busy && r_cnt == CntW'(1);
    assign o_p = s_t[W-1:0];
endmodule

[sv/egbce_modred.sv]
// Sequential reduction x mod n by restoring subtraction, one bit per cycle.
module egbce_modred (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [egbce_pkg::WordW-1:0]  i_x,
    input  logic [egbce_pkg::WordW-1:0]  i_n,
    output logic                         o_done,
    output logic [egbce_pkg::WordW-1:0]  o_r
);
    localparam int unsigned W = egbce_pkg::WordW;
    localparam int unsigned CntW = $clog2(W + 1);

    logic [CntW-1:0] r_cnt;
    logic            r_busy;
    logic [W-1:0]    r_rem, r_x;
    logic [W:0]      s_sh;
    logic [W-1:0]    s_nr;

    always_comb begin
        s_sh = {r_rem, r_x[W-1]};
        s_nr = s_sh[W-1:0];
        if (s_sh >= {1'b0, i_n}) s_nr = W'(s_sh - {1'b0, i_n});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= CntW'(W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CntW'(1)) r_busy <= 1'b0;
        end
        if (i_start) begin
            r_rem <= '0;
            r_x <= i_x;
        end else if (r_busy) begin
            r_rem <= s_nr;
            r_x <= {r_x[W-2:0], 1'b0};
        end
    end

    assign o_done = r_busy && r_cnt == CntW'(1);
    assign o_r = s_nr;
endmodule

[sv/egbce_front.sv]
// Front end: takes requests, picks operands and exponent, queues them.
module egbce_front #(
    parameter int unsigned QDepth = egbce_pkg::QueueDepth
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_kind,
    input  logic [egbce_pkg::WordW-1:0]  i_msg,
    input  logic [egbce_pkg::WordW-1:0]  i_nonce,
    input  logic [egbce_pkg::WordW-1:0]  i_c1,
    input  logic [egbce_pkg::WordW-1:0]  i_c2,
    input  logic [egbce_pkg::WordW-1:0]  i_p,
    input  logic [egbce_pkg::WordW-1:0]  i_g,
    input  logic [egbce_pkg::WordW-1:0]  i_e,
    input  logic [egbce_pkg::WordW-1:0]  i_d,
    output logic                         o_job_valid,
    input  logic                         i_job_take,
    output egbce_pkg::t_job              o_job
);
    localparam int unsigned W = egbce_pkg::WordW;
    localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int unsigned CntW = $clog2(QDepth + 1);

    egbce_pkg::t_job r_q [QDepth];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    egbce_pkg::t_job s_job;
    logic            s_push, s_pop;

    always_comb begin
        s_job.kind = i_kind;
        s_job.trivial = i_p < W'(2);
        if (i_kind == egbce_pkg::KindEncrypt) begin
            s_job.base_a = i_g;
            s_job.base_b = i_e;
            s_job.expo = i_nonce;
            s_job.factor = i_msg;
        end else begin
            s_job.base_a = i_c1;
            s_job.base_b = i_c1;
            s_job.expo = i_p - 1'b1 - i_d;
            s_job.factor = i_c2;
        end
    end

    assign o_ready = r_cnt != CntW'(QDepth);
    assign s_push = i_valid && o_ready;
    assign s_pop = i_job_take && o_job_valid;
    assign o_job_valid = r_cnt != '0;
    assign o_job = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (s_push) r_wr <= (r_wr == PtrW'(QDepth - 1)) ? '0 : r_wr + 1'b1;
            if (s_pop) r_rd <= (r_rd == PtrW'(QDepth - 1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + CntW'(s_push) - CntW'(s_pop);
        end
        if (s_push) r_q[r_wr] <= s_job;
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(QDepth)) else $error("queue count overflow");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CntW'(QDepth)) |-> !o_ready) else $error("full queue ready");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pop |-> r_cnt != '0) else $error("pop from empty queue");
endmodule

[sv/egbce_back.sv]
// Back end: runs one queued job through the reducer and the shared modular multiplier.
module egbce_back #(
    parameter int unsigned ExpBits = egbce_pkg::DefExpBits
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_job_valid,
    output logic                         o_job_take,
    input  egbce_pkg::t_job              i_job,
    input  logic [egbce_pkg::WordW-1:0]  i_p,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_kind,
    output logic [egbce_pkg::WordW-1:0]  o_first,
    output logic [egbce_pkg::WordW-1:0]  o_second
);
    localparam int unsigned W = egbce_pkg::WordW;
    localparam int unsigned BitW = $clog2(ExpBits);

    localparam logic [3:0] StIdle = 4'd0;
    localparam logic [3:0] StRedA = 4'd1;
    localparam logic [3:0] StRedB = 4'd2;
    localparam logic [3:0] StRedF = 4'd3;
    localparam logic [3:0] StOne = 4'd4;
    localparam logic [3:0] StSqA = 4'd5;
    localparam logic [3:0] StMulA = 4'd6;
    localparam logic [3:0] StSqB = 4'd7;
    localparam logic [3:0] StMulB = 4'd8;
    localparam logic [3:0] StFin = 4'd9;
    localparam logic [3:0] StOut = 4'd10;

    logic [3:0]      r_st;
    logic [BitW-1:0] r_bit;
    logic            r_wait;
    egbce_pkg::t_job r_job;
    logic [W-1:0]    r_a, r_b, r_f, r_acca, r_accb;
    logic [W-1:0]    r_first, r_second;
    logic            r_ovalid;
    logic            s_mstart, s_mdone, s_rstart, s_rdone, s_ebit, s_twin;
    logic [W-1:0]    s_ma, s_mb, s_mp, s_rx, s_rr;
    logic [ExpBits-1:0] s_expo;

    assign s_expo = ExpBits'(r_job.expo);
    assign s_ebit = s_expo[r_bit];
    assign s_twin = r_job.kind == egbce_pkg::KindDecrypt;

    egbce_modmul u_mul (.i_clk, .i_rst_n, .i_start(s_mstart), .i_a(s_ma),
        .i_b(s_mb), .i_n(i_p), .o_done(s_mdone), .o_p(s_mp));
    egbce_modred u_red (.i_clk, .i_rst_n, .i_start(s_rstart), .i_x(s_rx),
        .i_n(i_p), .o_done(s_rdone), .o_r(s_rr));

    always_comb begin
        s_ma = r_acca;
        s_mb = r_acca;
        case (r_st)
            StSqA: begin s_ma = r_acca; s_mb = r_acca; end
            StMulA: begin s_ma = r_a; s_mb = r_acca; end
            StSqB: begin s_ma = r_accb; s_mb = r_accb; end
            StMulB: begin s_ma = r_b; s_mb = r_accb; end
            StFin: begin s_ma = r_f; s_mb = r_accb; end
            default: ;
        endcase
        case (r_st)
            StRedA: s_rx = r_job.base_a;
            StRedB: s_rx = r_job.base_b;
            default: s_rx = r_job.factor;
        endcase
        s_mstart = !r_wait && (r_st == StSqA || r_st == StMulA || r_st == StSqB
                   || r_st == StMulB || r_st == StFin);
        s_rstart = !r_wait && (r_st == StRedA || r_st == StRedB || r_st == StRedF);
    end

    assign o_job_take = r_st == StIdle && i_job_valid;

    // Exponent bits run top down; for encrypt each bit squares both accumulators
    // and multiplies them when the bit is set, decrypt uses only the second one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= StIdle;
            r_wait <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_st == StOut && (!r_ovalid || i_ready)) r_ovalid <= 1'b1;
            else if (o_valid && i_ready) r_ovalid <= 1'b0;
            if (s_mstart || s_rstart) r_wait <= 1'b1;
            case (r_st)
                StIdle: if (i_job_valid) begin
                    r_job <= i_job;
                    r_st <= i_job.trivial ? StOut : StRedA;
                    r_first <= '0;
                    r_second <= '0;
                end
                StRedA: if (s_rdone) begin r_a <= s_rr; r_wait <= 1'b0; r_st <= StRedB; end
                StRedB: if (s_rdone) begin r_b <= s_rr; r_wait <= 1'b0; r_st <= StRedF; end
                StRedF: if (s_rdone) begin r_f <= s_rr; r_wait <= 1'b0; r_st <= StOne; end
                StOne: begin
                    r_acca <= W'(1);
                    r_accb <= W'(1);
                    r_bit <= BitW'(ExpBits - 1);
                    r_st <= s_twin ? StSqB : StSqA;
                end
                StSqA: if (s_mdone) begin
                    r_acca <= s_mp; r_wait <= 1'b0;
                    r_st <= s_ebit ? StMulA : StSqB;
                end
                StMulA: if (s_mdone) begin r_acca <= s_mp; r_wait <= 1'b0; r_st <= StSqB; end
                StSqB: if (s_mdone) begin
                    r_accb <= s_mp; r_wait <= 1'b0;
                    if (s_ebit) r_st <= StMulB;
                    else if (r_bit == '0) r_st <= StFin;
                    else begin r_bit <= r_bit - 1'b1; r_st <= s_twin ? StSqB : StSqA; end
                end
                StMulB: if (s_mdone) begin
                    r_accb <= s_mp; r_wait <= 1'b0;
                    if (r_bit == '0) r_st <= StFin;
                    else begin r_bit <= r_bit - 1'b1; r_st <= s_twin ? StSqB : StSqA; end
                end
                StFin: if (s_mdone) begin
                    r_wait <= 1'b0;
                    r_st <= StOut;
                    if (s_twin) begin r_first <= s_mp; r_second <= '0; end
                    else begin r_first <= r_acca; r_second <= s_mp; end
                end
                StOut: if (!r_ovalid || i_ready) r_st <= StIdle;
                default: r_st <= StIdle;
            endcase
        end
    end

    // Output register so the back end can start the next job, unless an earlier result is still untaken.
    always_ff @(posedge i_clk) begin
        if (r_st == StOut && (!r_ovalid || i_ready)) begin
            o_kind <= r_job.kind;
            o_first <= r_first;
            o_second <= r_second;
        end
    end
    assign o_valid = r_ovalid;

    a_one_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_mstart && s_rstart)) else $error("both units started");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_job_take |=> r_st != StIdle) else $error("job taken but idle");
    a_res_lt_p: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_mdone && i_p > W'(1)) |-> s_mp < i_p) else $error("product not reduced");
endmodule
